// ===== rtl/bpc_pkg.sv =====
//------------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the barometric compensation pipeline.
//------------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_CALIB = 2'd0,
        CFG_PRESS_A    = 2'd1,
        CFG_PRESS_B    = 2'd2,
        CFG_PRESS_C    = 2'd3
    } bpc_cfg_idx_t;

    // polynomial constants
    localparam int TFINE_OFS = 128000;
    localparam int P_BASE    = 1048576;
    localparam int P_SCALE   = 3125;
    localparam int SH_DIVSR  = 33;
    localparam int SH_Y1     = 25;
    localparam int SH_Y2     = 19;
    localparam int SH_SQRT   = 13;
    localparam int DIVSR_BIAS_BIT = 47;

    // divider geometry: 64 quotient bits, two per stage
    localparam int DIV_W      = 64;
    localparam int DIVSR_W    = 31;
    localparam int REM_W      = 32;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = DIV_W / DIV_STEPS;

    typedef struct packed {
        logic        fault;
        logic [15:0] temp;
    } bpc_tag_t;

    typedef struct packed {
        logic [31:0] pq;
        logic [15:0] temp;
        logic        fault;
    } bpc_res_t;

endpackage

`default_nettype wire

// ===== rtl/bpc_ifs.sv =====
//------------------------------------------------------------------------------
// bpc interfaces
// Sample, result and configuration channels (valid/ready).
//------------------------------------------------------------------------------
`default_nettype none

interface bpc_sample_if;
    logic        valid;
    logic        ready;
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
    modport source (output valid, raw_pressure, raw_temperature, input ready);
    modport sink   (input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface bpc_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pressure_q24_8;
    logic signed [15:0] temperature_centi;
    logic               divide_fault;
    modport source (output valid, pressure_q24_8, temperature_centi, divide_fault,
                    input ready);
    modport sink   (input valid, pressure_q24_8, temperature_centi, divide_fault,
                    output ready);
endinterface

interface bpc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [bpc_pkg::CFG_IDX_W-1:0]      index;
    logic [bpc_pkg::CFG_DATA_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bpc_mul64.sv =====
//------------------------------------------------------------------------------
// bpc_mul64
// Two-stage 64x64 multiplier keeping the low 64 bits (wraps mod 2^64).
//------------------------------------------------------------------------------
`default_nettype none

module bpc_mul64 (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic      [63:0] p
);

    logic [63:0] ll_reg, ll_next;
    logic [31:0] hl_reg, hl_next;
    logic [31:0] lh_reg, lh_next;
    logic [63:0] p_reg, p_next;

    // only the cross terms' low halves reach the low 64 bits
    always_comb
    begin
        ll_next = {32'd0, a[31:0]} * {32'd0, b[31:0]};
        hl_next = a[63:32] * b[31:0];
        lh_next = a[31:0] * b[63:32];
        p_next  = ll_reg + {hl_reg + lh_reg, 32'd0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= ll_next;
            hl_reg <= hl_next;
            lh_reg <= lh_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== rtl/bpc_div.sv =====
//------------------------------------------------------------------------------
// bpc_div
// Pipelined restoring divider, 64-bit unsigned dividend by 31-bit divisor,
// two quotient bits per stage. Sign and tag ride along.
//------------------------------------------------------------------------------
`default_nettype none

module bpc_div (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic [bpc_pkg::DIV_W-1:0]          dvd,
    input  wire logic [bpc_pkg::DIVSR_W-1:0]        dvs,
    input  wire logic                               neg_in,
    input  wire bpc_pkg::bpc_tag_t                  tag_in,
    output logic      [bpc_pkg::DIV_W-1:0]          quo,
    output logic                                    neg_out,
    output bpc_pkg::bpc_tag_t                       tag_out
);

    localparam int NS = bpc_pkg::DIV_STAGES;
    localparam int W  = bpc_pkg::DIV_W;
    localparam int DW = bpc_pkg::DIVSR_W;
    localparam int RW = bpc_pkg::REM_W;

    // nq holds unconsumed dividend bits on top, quotient bits shifted in below
    logic [W-1:0]      nq_reg   [0:NS-1];
    logic [W-1:0]      nq_next  [0:NS-1];
    logic [RW-1:0]     rem_reg  [0:NS-1];
    logic [RW-1:0]     rem_next [0:NS-1];
    logic [DW-1:0]     dvs_reg  [0:NS-1];
    logic              neg_reg  [0:NS-1];
    bpc_pkg::bpc_tag_t tag_reg  [0:NS-1];

    always_comb
    begin
        logic [RW-1:0] r;
        logic [RW-1:0] t;
        logic [W-1:0]  q;
        logic [DW-1:0] d;
        for (int s = 0; s < NS; s++)
        begin
            if (s == 0)
            begin
                r = '0;
                q = dvd;
                d = dvs;
            end
            else
            begin
                r = rem_reg[s-1];
                q = nq_reg[s-1];
                d = dvs_reg[s-1];
            end
            for (int k = 0; k < bpc_pkg::DIV_STEPS; k++)
            begin
                t = {r[RW-2:0], q[W-1]};
                q = {q[W-2:0], 1'b0};
                if (t >= {{(RW-DW){1'b0}}, d})
                begin
                    t    = t - {{(RW-DW){1'b0}}, d};
                    q[0] = 1'b1;
                end
                r = t;
            end
            nq_next[s]  = q;
            rem_next[s] = r;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvs_reg[0] <= dvs;
            neg_reg[0] <= neg_in;
            tag_reg[0] <= tag_in;
            for (int s = 1; s < NS; s++)
            begin
                dvs_reg[s] <= dvs_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
                tag_reg[s] <= tag_reg[s-1];
            end
            for (int s = 0; s < NS; s++)
            begin
                nq_reg[s]  <= nq_next[s];
                rem_reg[s] <= rem_next[s];
            end
        end
    end

    assign quo     = nq_reg[NS-1];
    assign neg_out = neg_reg[NS-1];
    assign tag_out = tag_reg[NS-1];

endmodule

`default_nettype wire

// ===== rtl/baro_pressure_temp_compensation_unit.sv =====
//------------------------------------------------------------------------------
// baro_pressure_temp_compensation_unit
// Integer barometric compensation: raw pressure/temperature in, temperature
// in 0.01 degC and pressure in Q24.8 Pa out.
//------------------------------------------------------------------------------
// Usage:
//   sample : raw_pressure / raw_temperature, one transaction per reading.
//   result : pressure_q24_8, temperature_centi, divide_fault, one transaction
//            per sample, in order.
//   cfg    : calibration writes (index 0..3), always ready; write only while
//            the pipeline is empty.
// Throughput is one sample per cycle while the skid register is empty. From the
// sample transaction to result valid there are 15 stages of polynomial and
// multiply, a 32-stage divider (two quotient bits per stage), 7 stages of
// correction, plus the output register.
// Reset clears all calibration words to zero and empties the pipeline.
// On a stall, the pipeline advances until a valid result enters the skid
// register and then holds; sample.ready drops while the skid is occupied.
//------------------------------------------------------------------------------
`default_nettype none

module baro_pressure_temp_compensation_unit (
    input  wire logic     clk,
    input  wire logic     rst_n,
    bpc_sample_if.sink    sample,
    bpc_result_if.source  result,
    bpc_cfg_if.sink       cfg
);

    localparam int LAT = 54;

    // calibration
    logic [47:0] temp_calib_reg;
    logic [63:0] press_a_reg;
    logic [63:0] press_b_reg;
    logic [15:0] press_c_reg;

    logic        [15:0] t1, p1;
    logic signed [15:0] t2, t3;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] p3x, p4x, p6x, p7x, p8x, p9x;

    assign t1 = temp_calib_reg[15:0];
    assign t2 = temp_calib_reg[31:16];
    assign t3 = temp_calib_reg[47:32];
    assign p1 = press_a_reg[15:0];
    assign p2 = press_a_reg[31:16];
    assign p3 = press_a_reg[47:32];
    assign p4 = press_a_reg[63:48];
    assign p5 = press_b_reg[15:0];
    assign p6 = press_b_reg[31:16];
    assign p7 = press_b_reg[47:32];
    assign p8 = press_b_reg[63:48];
    assign p9 = press_c_reg;
    assign p3x = 64'(p3);
    assign p4x = 64'(p4);
    assign p6x = 64'(p6);
    assign p7x = 64'(p7);
    assign p8x = 64'(p8);
    assign p9x = 64'(p9);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_calib_reg <= '0;
            press_a_reg    <= '0;
            press_b_reg    <= '0;
            press_c_reg    <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                bpc_pkg::CFG_TEMP_CALIB: temp_calib_reg <= cfg.data[47:0];
                bpc_pkg::CFG_PRESS_A:    press_a_reg    <= cfg.data;
                bpc_pkg::CFG_PRESS_B:    press_b_reg    <= cfg.data;
                bpc_pkg::CFG_PRESS_C:    press_c_reg    <= cfg.data[15:0];
                default: ;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    // pipeline control
    logic           en;
    logic [LAT-1:0] vld_reg;
    logic           skid_valid_reg;
    logic           out_valid_reg;
    bpc_pkg::bpc_res_t out_reg, skid_reg, fin_reg, fin_next;

    assign en           = !skid_valid_reg;
    assign sample.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], sample.valid};
        end
    end

    // datapath registers
    logic        [19:0] adcp_reg [0:10];
    logic        [19:0] adct_reg;
    logic signed [18:0] a_reg, a_next;
    logic signed [17:0] b_reg, b_next;
    logic signed [34:0] m1_reg, m1_next;
    logic signed [35:0] bsq;
    logic        [31:0] bb_reg;
    logic signed [23:0] v1_reg, v1d_reg;
    logic        [19:0] bbs_reg;
    logic signed [36:0] m2_reg, m2_next;
    logic signed [31:0] tfine_reg, tfine_next;
    logic signed [31:0] t5, t8;
    logic        [15:0] temp_next;
    logic        [15:0] tempd_reg [0:7];
    logic signed [31:0] x1_reg, x1_next;
    logic signed [63:0] sq_reg, sq_next;
    logic signed [47:0] m5w, m2pw;
    logic signed [63:0] m5_reg [0:2];
    logic signed [63:0] m2p_reg [0:2];
    logic signed [63:0] mp6, mp3;
    logic signed [63:0] x2_reg, x2_next;
    logic signed [63:0] x1b_reg, x1b_next;
    logic        [20:0] pdiff;
    logic signed [63:0] num_reg [0:1];
    logic signed [63:0] num_next;
    logic signed [63:0] prod;
    logic        [63:0] p1_op;
    logic signed [30:0] d_reg;
    logic signed [63:0] num2_reg, num2_next;
    logic        [63:0] ua_reg, ua_next;
    logic        [30:0] ub_reg, ub_next;
    logic               neg_reg;
    bpc_pkg::bpc_tag_t  tag14_reg, tag14_next;
    logic        [63:0] quo;
    logic               dneg;
    bpc_pkg::bpc_tag_t  dtag;
    logic signed [63:0] p_reg, p_next;
    bpc_pkg::bpc_tag_t  tagp_reg [0:5];
    logic signed [63:0] s_reg [0:1];
    logic signed [63:0] s_next;
    logic signed [63:0] pd_reg [0:3];
    logic signed [63:0] m9, m8, m9s;
    logic signed [63:0] y2_reg [0:1];
    logic signed [63:0] pres_reg, pres_next;

    always_comb
    begin
        a_next  = $signed({2'b00, adct_reg[19:3]}) - $signed({2'b00, t1, 1'b0});
        b_next  = $signed({2'b00, adct_reg[19:4]}) - $signed({2'b00, t1});
        m1_next = a_reg * t2;
        bsq     = b_reg * b_reg;
        m2_next = $signed({1'b0, bbs_reg}) * t3;
        tfine_next = 32'(v1d_reg) + 32'(m2_reg >>> 14);

        t5 = tfine_reg * 32'sd5 + 32'sd128;
        t8 = t5 >>> 8;
        priority if (t8 > 32'sd32767)
            temp_next = 16'h7fff;
        else if (t8 < -32'sd32768)
            temp_next = 16'h8000;
        else
            temp_next = t8[15:0];
        x1_next = tfine_reg - 32'(bpc_pkg::TFINE_OFS);

        sq_next = 64'(x1_reg) * 64'(x1_reg);
        m5w     = x1_reg * p5;
        m2pw    = x1_reg * p2;

        x2_next  = mp6 + (m5_reg[2] <<< 17) + (p4x <<< 35);
        x1b_next = (mp3 >>> 8) + (m2p_reg[2] <<< 12);

        pdiff    = 21'(bpc_pkg::P_BASE) - {1'b0, adcp_reg[10]};
        num_next = $signed({43'd0, pdiff} << 31) - x2_reg;
        p1_op    = 64'(x1b_reg) + (64'd1 << bpc_pkg::DIVSR_BIAS_BIT);

        num2_next = num_reg[1] * 64'sd3125;

        ua_next = num2_reg[63] ? (~num2_reg + 64'd1) : num2_reg;
        ub_next = d_reg[30] ? (~d_reg + 31'd1) : d_reg;
        tag14_next.fault = (d_reg == '0);
        tag14_next.temp  = tempd_reg[7];

        p_next = dneg ? $signed(~quo + 64'd1) : $signed(quo);
        s_next = p_reg >>> bpc_pkg::SH_SQRT;

        pres_next = ((pd_reg[3] + (m9s >>> bpc_pkg::SH_Y1) + y2_reg[1]) >>> 8)
                    + (p7x <<< 4);

        fin_next.temp  = tagp_reg[5].temp;
        fin_next.fault = tagp_reg[5].fault;
        priority if (tagp_reg[5].fault)
            fin_next.pq = '0;
        else if (pres_reg > 64'sd2147483647)
            fin_next.pq = 32'h7fff_ffff;
        else if (pres_reg < -64'sd2147483648)
            fin_next.pq = 32'h8000_0000;
        else
            fin_next.pq = pres_reg[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            adcp_reg[0] <= sample.raw_pressure[23:4];
            adct_reg    <= sample.raw_temperature[23:4];
            for (int i = 1; i <= 10; i++)
                adcp_reg[i] <= adcp_reg[i-1];
            a_reg     <= a_next;
            b_reg     <= b_next;
            m1_reg    <= m1_next;
            bb_reg    <= bsq[31:0];
            v1_reg    <= 24'(m1_reg >>> 11);
            bbs_reg   <= bb_reg[31:12];
            v1d_reg   <= v1_reg;
            m2_reg    <= m2_next;
            tfine_reg <= tfine_next;
            tempd_reg[0] <= temp_next;
            for (int i = 1; i <= 7; i++)
                tempd_reg[i] <= tempd_reg[i-1];
            x1_reg     <= x1_next;
            sq_reg     <= sq_next;
            m5_reg[0]  <= 64'(m5w);
            m2p_reg[0] <= 64'(m2pw);
            for (int i = 1; i <= 2; i++)
            begin
                m5_reg[i]  <= m5_reg[i-1];
                m2p_reg[i] <= m2p_reg[i-1];
            end
            x2_reg     <= x2_next;
            x1b_reg    <= x1b_next;
            num_reg[0] <= num_next;
            num_reg[1] <= num_reg[0];
            d_reg      <= prod[63:bpc_pkg::SH_DIVSR];
            num2_reg   <= num2_next;
            ua_reg     <= ua_next;
            ub_reg     <= ub_next;
            neg_reg    <= num2_reg[63] ^ d_reg[30];
            tag14_reg  <= tag14_next;
            p_reg      <= p_next;
            tagp_reg[0] <= dtag;
            for (int i = 1; i <= 5; i++)
                tagp_reg[i] <= tagp_reg[i-1];
            s_reg[0]  <= s_next;
            s_reg[1]  <= s_reg[0];
            pd_reg[0] <= p_reg;
            for (int i = 1; i <= 3; i++)
                pd_reg[i] <= pd_reg[i-1];
            y2_reg[0] <= m8 >>> bpc_pkg::SH_Y2;
            y2_reg[1] <= y2_reg[0];
            pres_reg  <= pres_next;
            fin_reg   <= fin_next;
        end
    end

    bpc_mul64 u_mul_p6 (.clk(clk), .en(en), .a(sq_reg), .b(p6x), .p(mp6));
    bpc_mul64 u_mul_p3 (.clk(clk), .en(en), .a(sq_reg), .b(p3x), .p(mp3));
    bpc_mul64 u_mul_p1 (.clk(clk), .en(en), .a(p1_op), .b({48'd0, p1}), .p(prod));
    bpc_mul64 u_mul_p9 (.clk(clk), .en(en), .a(p9x), .b(s_next), .p(m9));
    bpc_mul64 u_mul_p8 (.clk(clk), .en(en), .a(p8x), .b(p_reg), .p(m8));
    bpc_mul64 u_mul_sq (.clk(clk), .en(en), .a(m9), .b(s_reg[1]), .p(m9s));

    bpc_div u_div (
        .clk     (clk),
        .en      (en),
        .dvd     (ua_reg),
        .dvs     (ub_reg),
        .neg_in  (neg_reg),
        .tag_in  (tag14_reg),
        .quo     (quo),
        .neg_out (dneg),
        .tag_out (dtag)
    );

    // output register with skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !result.ready)
        begin
            if (en && vld_reg[LAT-1])
                skid_valid_reg <= 1'b1;
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !result.ready)
        begin
            if (en && vld_reg[LAT-1])
                skid_reg <= fin_reg;
        end
        else if (skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
        else
        begin
            out_reg <= fin_reg;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.pressure_q24_8    = out_reg.pq;
    assign result.temperature_centi = out_reg.temp;
    assign result.divide_fault      = out_reg.fault;

endmodule

`default_nettype wire
